// ===== rtl/rdsm_pkg.sv =====
`timescale 1ns / 1ps
// rdsm_pkg: constants, request codes and sequencer states for the regex matcher
// no dependencies

package rdsm_pkg;

  localparam int unsigned PatternMax = 32;
  localparam int unsigned IdxW       = $clog2(PatternMax);
  localparam int unsigned LenW       = $clog2(PatternMax + 1);
  localparam int unsigned RowW       = PatternMax + 1;
  localparam int unsigned ChW        = 8;
  localparam int unsigned CountW     = 6;
  localparam int unsigned OutDataW   = 8;

  localparam logic [ChW-1:0] StarChar = 8'h2A;
  localparam logic [ChW-1:0] DotChar  = 8'h2E;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_RESTART = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

endpackage

// ===== rtl/regex_dot_star_matcher_top.sv =====
`timescale 1ns / 1ps
// regex_dot_star_matcher_top: streaming matcher of text against a '.'/'*' pattern
// depends on rdsm_pkg

// The block takes one request per input transfer and returns one result transfer for
// each. For clear, append and restart requests the accept cycle updates the pattern
// store and the rows, and the finish state then loads the result. A text byte with a
// non-empty pattern first passes through a walk: one shared step unit walks the pattern
// positions one per cycle against the stored row, fed by the single read port of the
// pattern memory, and the finish state then loads the result. The input is not ready
// while a request is in work; a finished result waits in the output register, so the
// block takes the next request while it is pending, and only stalls at the finish
// state when the previous result is still untaken.
module regex_dot_star_matcher_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [rdsm_pkg::ChW-1:0]        s_axis_tdata_i,   // [7:0] ch
  input  logic [1:0]                      s_axis_tuser_i,   // [1:0] req_type
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [rdsm_pkg::OutDataW-1:0]   m_axis_tdata_o    // [0] matched, [1] status,
                                                            // [7:2] pattern_count
);
  import rdsm_pkg::*;

  state_e state_q, state_d;

  logic [ChW-1:0]  pat_mem [PatternMax];
  logic [ChW-1:0]  rd_q;
  logic [IdxW-1:0] rd_addr;

  logic [LenW-1:0] len_q, len_d;
  logic [RowW-1:0] empty_row_q, empty_row_d;
  logic [RowW-1:0] match_row_q, match_row_d;
  logic [RowW-1:0] next_row_q, next_row_d;
  logic [IdxW-1:0] j_q, j_d;
  logic            n1_q, n1_d;      // next[j]
  logic            n2_q, n2_d;      // next[j-1]
  logic [ChW-1:0]  prev_q, prev_d;  // pattern byte j-1
  logic [ChW-1:0]  ch_q, ch_d;
  logic            status_q, status_d;

  logic                 out_valid_q, out_valid_d;
  logic [OutDataW-1:0]  out_data_q, out_data_d;

  logic            accept;
  logic            mem_we;
  logic            step_bit;
  logic            last_step;
  logic [LenW-1:0] jp1;
  logic [LenW-1:0] j_ext;
  logic            append_bit;
  logic            out_free;
  req_e            req;

  assign req      = req_e'(s_axis_tuser_i);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign j_ext    = LenW'(j_q);
  assign jp1      = j_ext + LenW'(1);
  assign last_step = (jp1 == len_q);

  // pattern memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pat_mem[len_q[IdxW-1:0]] <= s_axis_tdata_i;
    end
    rd_q <= pat_mem[rd_addr];
  end

  // shared step unit: one pattern position against the current text byte
  always_comb begin
    step_bit = 1'b0;
    if (rd_q == StarChar) begin
      if (j_q == '0) begin
        step_bit = 1'b0;  // leading star never matches
      end else if (prev_q != ch_q && prev_q != DotChar) begin
        step_bit = n2_q;
      end else begin
        step_bit = n1_q | match_row_q[jp1] | n2_q;
      end
    end else if (rd_q == DotChar || rd_q == ch_q) begin
      step_bit = match_row_q[j_ext];
    end
  end

  assign append_bit = (s_axis_tdata_i == StarChar) && (len_q != '0)
                      && empty_row_q[len_q - LenW'(1)];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req == REQ_TEXT && len_q != '0) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_WALK: begin
        if (last_step) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    rd_addr     = '0;
    mem_we      = 1'b0;
    len_d       = len_q;
    empty_row_d = empty_row_q;
    match_row_d = match_row_q;
    next_row_d  = next_row_q;
    j_d         = j_q;
    n1_d        = n1_q;
    n2_d        = n2_q;
    prev_d      = prev_q;
    ch_d        = ch_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = 1'b0;
          case (req)
            REQ_CLEAR: begin
              len_d       = '0;
              empty_row_d = RowW'(1);
              match_row_d = RowW'(1);
            end
            REQ_APPEND: begin
              if (len_q >= LenW'(PatternMax)) begin
                status_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                empty_row_d[len_q + LenW'(1)] = append_bit;
                match_row_d = empty_row_d;
                len_d = len_q + LenW'(1);
              end
            end
            REQ_TEXT: begin
              ch_d       = s_axis_tdata_i;
              j_d        = '0;
              n1_d       = 1'b0;
              n2_d       = 1'b0;
              prev_d     = '0;
              next_row_d = '0;
              if (len_q == '0) begin
                match_row_d = '0;
              end
            end
            REQ_RESTART: begin
              match_row_d = empty_row_q;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        rd_addr = j_q + IdxW'(1);
        next_row_d[jp1] = step_bit;
        n2_d   = n1_q;
        n1_d   = step_bit;
        prev_d = rd_q;
        j_d    = j_q + IdxW'(1);
        if (last_step) begin
          match_row_d = next_row_d;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {CountW'(len_q), status_q, match_row_q[len_q]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      empty_row_q <= RowW'(1);
      match_row_q <= RowW'(1);
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      empty_row_q <= empty_row_d;
      match_row_q <= match_row_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_row_q <= next_row_d;
    j_q        <= j_d;
    n1_q       <= n1_d;
    n2_q       <= n2_d;
    prev_q     <= prev_d;
    ch_q       <= ch_d;
    out_data_q <= out_data_d;
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(PatternMax))
    else $error("pattern length beyond capacity");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> jp1 <= len_q)
    else $error("walk index past pattern length");

  a_text_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req == REQ_TEXT && len_q != '0 |=> state_q == ST_WALK)
    else $error("text byte did not start a walk");

  a_count_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> m_axis_tdata_o[7:2] == CountW'(len_q))
    else $error("result count differs from stored length");

endmodule

// ===== test/regex_dot_star_matcher_top_tb.sv =====
`timescale 1ns / 1ps
// regex_dot_star_matcher_top_tb: self-checking bench for the '.'/'*' pattern matcher
// predicts most results from its own copy of the pattern store and match rows
// depends on rdsm_pkg and regex_dot_star_matcher_top

module regex_dot_star_matcher_top_tb;
  import rdsm_pkg::*;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned RandItems  = 1100;
  localparam int unsigned CalmItems  = 150;
  localparam int unsigned HoldCycles = 300;

  // result transfer layout, lowest bit first: matched, status, pattern_count
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              status;
    logic              matched;
  } match_res_t;

  typedef struct {
    req_e       req;
    logic [7:0] ch;
    bit         fixed;
    match_res_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [ChW-1:0] s_data = '0;
  logic [1:0] s_user = REQ_CLEAR;
  logic m_ready = 1'b0;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  regex_dot_star_matcher_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // predictor state
  logic [ChW-1:0]  pat_mem [PatternMax];
  int unsigned     pat_len = 0;
  logic [RowW-1:0] empty_row = RowW'(1);
  logic [RowW-1:0] match_row = RowW'(1);

  match_res_t  match_q [$];
  dir_row_t    dir_q [$];
  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned cyc = 0;
  bit          idle_on = 1'b1;
  bit          hold_go = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic match_res_t mk_res(logic m, logic s, logic [CountW-1:0] n);
    match_res_t r;
    r.matched = m;
    r.status  = s;
    r.count   = n;
    return r;
  endfunction

  // advance the expected matcher state by one request
  function automatic match_res_t match_step(req_e r, logic [ChW-1:0] c);
    match_res_t      res;
    logic [RowW-1:0] nxt;
    logic [ChW-1:0]  p;
    logic [ChW-1:0]  prev;
    res.status = 1'b0;
    case (r)
      REQ_CLEAR: begin
        pat_len   = 0;
        empty_row = RowW'(1);
        match_row = RowW'(1);
      end
      REQ_APPEND: begin
        if (pat_len >= PatternMax) begin
          res.status = 1'b1;
        end else begin
          pat_mem[pat_len] = c;
          // a star can drop the element before it, but a leading star never matches
          if (c == StarChar && pat_len >= 1) empty_row[pat_len+1] = empty_row[pat_len-1];
          else empty_row[pat_len+1] = 1'b0;
          pat_len   = pat_len + 1;
          match_row = empty_row;
        end
      end
      REQ_TEXT: begin
        nxt = '0;
        for (int j = 0; j < pat_len; j++) begin
          p = pat_mem[j];
          if (p == StarChar) begin
            if (j == 0) begin
              nxt[1] = 1'b0;
            end else begin
              prev = pat_mem[j-1];
              if (prev != c && prev != DotChar) nxt[j+1] = nxt[j-1];
              else nxt[j+1] = nxt[j] | match_row[j+1] | nxt[j-1];
            end
          end else if (p == DotChar || p == c) begin
            nxt[j+1] = match_row[j];
          end else begin
            nxt[j+1] = 1'b0;
          end
        end
        match_row = nxt;
      end
      default: begin
        match_row = empty_row;
      end
    endcase
    res.matched = match_row[pat_len];
    res.count   = CountW'(pat_len);
    return res;
  endfunction

  // offer one request and queue its expected result once the transfer happens
  task automatic send_req(req_e r, logic [ChW-1:0] c, bit fixed = 1'b0,
                          match_res_t fixed_res = '0);
    match_res_t pred;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= r;
    s_data  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = match_step(r, c);
    match_q.push_back(fixed ? fixed_res : pred);
    n_sent++;
  endtask

  function automatic logic [ChW-1:0] pat_byte();
    int unsigned k = $urandom_range(0, 15);
    if (k < 5) return "a";
    if (k < 8) return "b";
    if (k < 10) return DotChar;
    if (k < 14) return StarChar;
    return ChW'($urandom_range(0, 255));
  endfunction

  function automatic logic [ChW-1:0] text_byte();
    int unsigned k = $urandom_range(0, 11);
    if (k < 4) return "a";
    if (k < 7) return "b";
    if (k < 9) return StarChar;
    return ChW'($urandom_range(0, 255));
  endfunction

  // clear or restart, append pattern bytes, then a few texts built to follow them, some spoiled
  task automatic run_sequence();
    logic [ChW-1:0] pq [$];
    logic [ChW-1:0] tq [$];
    int             i;
    logic [ChW-1:0] e;
    if ($urandom_range(0, 4) != 0) send_req(REQ_CLEAR, ChW'($urandom_range(0, 255)));
    else send_req(REQ_RESTART, ChW'($urandom_range(0, 255)));
    // now and then run past the store size to see the dropped appends
    repeat (($urandom_range(0, 15) == 0) ? $urandom_range(30, 35) : $urandom_range(1, 6))
    begin
      e = pat_byte();
      pq.push_back(e);
      send_req(REQ_APPEND, e);
    end
    repeat ($urandom_range(1, 3)) begin
      tq.delete();
      i = 0;
      while (i < pq.size()) begin
        e = pq[i];
        if (i + 1 < pq.size() && pq[i+1] == StarChar) begin
          repeat ($urandom_range(0, 3)) tq.push_back((e == DotChar) ? text_byte() : e);
          i += 2;
        end else begin
          tq.push_back((e == DotChar) ? text_byte() : e);
          i++;
        end
      end
      if ($urandom_range(0, 3) == 0 && tq.size() > 0)
        tq[$urandom_range(0, tq.size() - 1)] = text_byte();
      if ($urandom_range(0, 3) == 0) tq.push_back(text_byte());
      foreach (tq[k]) send_req(REQ_TEXT, tq[k]);
      send_req(REQ_RESTART, ChW'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_dir(req_e r, logic [ChW-1:0] c, bit fixed = 1'b0,
                         match_res_t res = '0);
    dir_row_t row;
    row.req   = r;
    row.ch    = c;
    row.fixed = fixed;
    row.res   = res;
    dir_q.push_back(row);
  endtask

  // result side: check each transfer, stall in random bursts or one long hold
  initial begin
    match_res_t got;
    match_res_t want;
    int unsigned stall_left;
    int unsigned hold_cnt;
    stall_left = 0;
    hold_cnt   = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_ready) begin
        got = match_res_t'(m_axis_tdata_o);
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          err_cnt++;
        end else begin
          want = match_q.pop_front();
          if (got.matched !== want.matched) begin
            $display("%0t: matched expected %0d actual %0d", $time, want.matched,
                     got.matched);
            err_cnt++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            err_cnt++;
          end
          if (got.count !== want.count) begin
            $display("%0t: pattern_count expected %0d actual %0d", $time, want.count,
                     got.count);
            err_cnt++;
          end
        end
      end
      if (hold_go) begin
        hold_go  = 1'b0;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin
    bit held;
    bit drained;
    int unsigned dir_n;
    held    = 1'b0;
    drained = 1'b0;

    add_dir(REQ_RESTART, 8'h00, 1'b1, mk_res(1'b1, 1'b0, 6'd0));
    add_dir(REQ_TEXT,    8'h00, 1'b1, mk_res(1'b0, 1'b0, 6'd0));
    add_dir(REQ_TEXT,    8'hFF, 1'b1, mk_res(1'b0, 1'b0, 6'd0));
    add_dir(REQ_CLEAR,   8'hFF, 1'b1, mk_res(1'b1, 1'b0, 6'd0));
    add_dir(REQ_APPEND,  StarChar);   // leading star
    add_dir(REQ_TEXT,    StarChar);
    add_dir(REQ_RESTART, 8'h00);
    add_dir(REQ_CLEAR,   8'h00);
    add_dir(REQ_APPEND,  "a");
    add_dir(REQ_APPEND,  StarChar);   // a* matches empty text
    add_dir(REQ_TEXT,    "a");
    add_dir(REQ_TEXT,    "a");
    add_dir(REQ_TEXT,    "b");
    add_dir(REQ_RESTART, 8'hFF);
    add_dir(REQ_APPEND,  DotChar);
    add_dir(REQ_TEXT,    "z");
    add_dir(REQ_APPEND,  StarChar);
    add_dir(REQ_APPEND,  StarChar);   // star after star repeats a literal star
    add_dir(REQ_TEXT,    StarChar);
    add_dir(REQ_TEXT,    "q");
    add_dir(REQ_CLEAR,   8'h00);
    add_dir(REQ_APPEND,  8'hFF);
    add_dir(REQ_APPEND,  8'h00);
    add_dir(REQ_TEXT,    8'hFF);
    add_dir(REQ_TEXT,    8'h00);
    dir_n = dir_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[k]) send_req(dir_q[k].req, dir_q[k].ch, dir_q[k].fixed, dir_q[k].res);

    while (n_sent < dir_n + RandItems) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6))
          send_req(req_e'($urandom_range(0, 3)), ChW'($urandom_range(0, 255)));
      end else begin
        run_sequence();
      end
      if (!held && n_sent >= dir_n + 300) begin
        hold_go = 1'b1;
        held    = 1'b1;
      end
      if (!drained && n_sent >= dir_n + 600) begin
        s_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge clk_i);
        drained = 1'b1;
      end
      if (n_sent >= dir_n + RandItems - CalmItems) idle_on = 1'b0;
    end

    s_valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
